// File: src/swts_pkg.sv
// shared types and constants for the switch timestamp tag decoder
// used by swts_decide and switch_timestamp_tag_decode_core; no dependencies
package swts_pkg;

  // time constants
  localparam logic [29:0] NS_PER_S    = 30'd1000000000;
  localparam logic [32:0] ROLLOVER_NS = 33'd4000000000;

  // 2^64 ns split into seconds and nanoseconds, seconds taken modulo 2^32,
  // with the 4 s rollover already removed from the seconds part
  localparam logic [31:0] WRAP_SEC_BASE = 32'd1266874885;
  localparam logic [29:0] WRAP_NS_BASE  = 30'd709551616;

  // frame checks
  localparam logic [15:0] LLDP_TYPE       = 16'h88CC;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd26;

  // configuration reset values
  localparam logic        RST_STRIP_ENABLE = 1'b1;
  localparam logic [31:0] RST_WINDOW_NS    = 32'd1000000000;
  localparam logic        RST_OUI_ENABLE   = 1'b0;
  localparam logic [23:0] RST_OUI_VALUE    = 24'd0;
  localparam logic [15:0] RST_ETHERTYPE    = 16'd53899;
  localparam logic [15:0] RST_SUBTYPE      = 16'd1;
  localparam logic [15:0] RST_VERSION_TAI  = 16'd16;
  localparam logic [15:0] RST_VERSION_UTC  = 16'd272;

  // result kind
  typedef enum logic [1:0] {
    CLASS_GOOD    = 2'd0,
    CLASS_IGNORED = 2'd1,
    CLASS_BAD     = 2'd2
  } frame_class_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STRIP_ENABLE = 3'd0,
    REG_WINDOW_NS    = 3'd1,
    REG_OUI_ENABLE   = 3'd2,
    REG_OUI_VALUE    = 3'd3,
    REG_ETHERTYPE    = 3'd4,
    REG_SUBTYPE      = 3'd5,
    REG_VERSION_TAI  = 3'd6,
    REG_VERSION_UTC  = 3'd7
  } cfg_reg_t;

  // one item entering the decision stage
  typedef struct packed {
    frame_class_t cls;
    logic         in_window;  // tag time inside the rollover window
    logic [63:0]  diff;       // tag - nic
    logic [63:0]  diff_roll;  // tag - 4 s - nic
    logic [63:0]  diff_neg;   // nic - tag
    logic [31:0]  tag_sec;
    logic [29:0]  tag_nsec;
    logic [31:0]  nic_sec;
    logic [29:0]  nic_nsec;
  } calc_t;

  // one finished result
  typedef struct packed {
    frame_class_t cls;
    logic [31:0]  sec;
    logic [29:0]  nsec;
    logic         strip;
    logic         fixed;
  } result_t;

endpackage

// File: src/swts_decide.sv
// rollover decision and time formatting, holds the nic-minus-tag delta
// depends on swts_pkg
module swts_decide (
  input  logic            clk,
  input  logic            rst,
  input  logic            strip_enable,
  input  swts_pkg::calc_t item,
  input  logic            take,     // item moves into the result register
  output swts_pkg::result_t result
);
  import swts_pkg::*;

  logic [63:0] delta;
  logic        delta_valid;

  logic [63:0] dist_keep;
  logic [63:0] dist_roll;
  logic [63:0] mag_keep;
  logic [63:0] mag_roll;
  logic        good;
  logic        fix;
  logic [30:0] wrap_nsum;
  logic        wrap_carry;

  // distances of both candidates from the expected tag time
  assign dist_keep = item.diff + delta;
  assign dist_roll = item.diff_roll + delta;
  assign mag_keep  = dist_keep[63] ? (~dist_keep + 64'd1) : dist_keep;
  assign mag_roll  = dist_roll[63] ? (~dist_roll + 64'd1) : dist_roll;

  assign good = (item.cls == CLASS_GOOD);
  assign fix  = good && item.in_window && delta_valid && (mag_roll < mag_keep);

  // corrected time below 4 s wraps through 2^64 ns
  assign wrap_nsum  = {1'b0, WRAP_NS_BASE} + {1'b0, item.tag_nsec};
  assign wrap_carry = (wrap_nsum >= {1'b0, NS_PER_S});

  // result fields
  always_comb begin
    result.cls   = item.cls;
    result.sec   = item.nic_sec;
    result.nsec  = item.nic_nsec;
    result.strip = 1'b0;
    result.fixed = 1'b0;
    if (good) begin
      result.strip = strip_enable;
      result.fixed = fix;
      if (!fix) begin
        result.sec  = item.tag_sec;
        result.nsec = item.tag_nsec;
      end else if (item.tag_sec >= 32'd4) begin
        result.sec  = item.tag_sec - 32'd4;
        result.nsec = item.tag_nsec;
      end else begin
        result.sec  = WRAP_SEC_BASE + item.tag_sec + {31'd0, wrap_carry};
        result.nsec = wrap_carry ? 30'(wrap_nsum - {1'b0, NS_PER_S}) : wrap_nsum[29:0];
      end
    end
  end

  // delta refresh outside the window
  always_ff @(posedge clk) begin
    if (rst) begin
      delta       <= 64'd0;
      delta_valid <= 1'b0;
    end else if (take && good && !item.in_window) begin
      delta       <= item.diff_neg;
      delta_valid <= 1'b1;
    end
  end

endmodule

// File: src/switch_timestamp_tag_decode_core.sv
// switch timestamp tag decoder top level: input, product, difference and result stages
// depends on swts_pkg and swts_decide
//
// channel  dir  request when             payload
// s_*      in   s_tvalid && s_tready     s_tdata frame header and nic time, s_tuser crc error
// m_*      out  m_tvalid && m_tready     m_tdata time and flags, m_tuser frame class
// cfg_*    in   cfg_valid && cfg_ready   cfg_index register, cfg_data value
//
// one request per cycle sustained while m_tready is high; a taken request passes through these registers in order
// (input register, multiply stage, difference stage, result register)
// the delta feedback closes within the decision stage, so requests follow back to back
// rst is synchronous: clears stage valids, the delta and loads register defaults
// ready travels back through empty stages, so requests are taken while a result waits
module switch_timestamp_tag_decode_core (
  input  logic         clk,
  input  logic         rst,
  // eth_type[15:0], source_oui[39:16], frame_length[55:40], tag_subtype[71:56],
  // tag_version[87:72], tag_seconds[119:88], tag_nanoseconds[151:120],
  // nic_seconds[183:152], nic_nanoseconds[213:184], zero fill[215:214]
  input  logic [215:0] s_tdata,
  input  logic         s_tuser,   // crc_error
  input  logic         s_tvalid,
  output logic         s_tready,
  // out_seconds[31:0], out_nanoseconds[61:32], strip_tag[62], rollover_fixed[63]
  output logic [63:0]  m_tdata,
  output logic [1:0]   m_tuser,   // frame_class
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import swts_pkg::*;

  // configuration registers
  logic        strip_enable;
  logic [31:0] window_ns;
  logic        oui_enable;
  logic [23:0] oui_value;
  logic [15:0] tag_ethertype;
  logic [15:0] subtype_value;
  logic [15:0] version_tai;
  logic [15:0] version_utc;

  // stage a: input register
  logic        a_valid;
  logic [15:0] a_etype;
  logic [23:0] a_oui;
  logic        a_crc;
  logic [15:0] a_flen;
  logic [15:0] a_sub;
  logic [15:0] a_ver;
  logic [31:0] a_tsec;
  logic [31:0] a_tnsec;
  logic [31:0] a_nsec;
  logic [29:0] a_nnsec;

  // stage b: products and class
  logic         b_valid;
  frame_class_t b_cls;
  logic         b_inside;
  logic [61:0]  b_tag_ns;
  logic [61:0]  b_nic_ns;
  logic [31:0]  b_tsec;
  logic [29:0]  b_tnsec;
  logic [31:0]  b_nsec;
  logic [29:0]  b_nnsec;

  // stage c: differences
  logic  c_valid;
  calc_t c_item;

  // result register
  logic    r_valid;
  result_t r_res;
  result_t dec_res;

  logic a_ready;
  logic b_ready;
  logic c_ready;
  logic r_ready;

  frame_class_t a_cls;
  logic         a_ignored;
  logic         a_bad;
  logic [32:0]  a_lower;
  logic [32:0]  a_threshold;

  // stage handshakes
  assign r_ready  = !r_valid || m_tready;
  assign c_ready  = !c_valid || r_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_enable  <= RST_STRIP_ENABLE;
      window_ns     <= RST_WINDOW_NS;
      oui_enable    <= RST_OUI_ENABLE;
      oui_value     <= RST_OUI_VALUE;
      tag_ethertype <= RST_ETHERTYPE;
      subtype_value <= RST_SUBTYPE;
      version_tai   <= RST_VERSION_TAI;
      version_utc   <= RST_VERSION_UTC;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_STRIP_ENABLE: strip_enable  <= cfg_data[0];
        REG_WINDOW_NS:    window_ns     <= cfg_data;
        REG_OUI_ENABLE:   oui_enable    <= cfg_data[0];
        REG_OUI_VALUE:    oui_value     <= cfg_data[23:0];
        REG_ETHERTYPE:    tag_ethertype <= cfg_data[15:0];
        REG_SUBTYPE:      subtype_value <= cfg_data[15:0];
        REG_VERSION_TAI:  version_tai   <= cfg_data[15:0];
        REG_VERSION_UTC:  version_utc   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage a capture
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_etype <= s_tdata[15:0];
      a_oui   <= s_tdata[39:16];
      a_crc   <= s_tuser;
      a_flen  <= s_tdata[55:40];
      a_sub   <= s_tdata[71:56];
      a_ver   <= s_tdata[87:72];
      a_tsec  <= s_tdata[119:88];
      a_tnsec <= s_tdata[151:120];
      a_nsec  <= s_tdata[183:152];
      a_nnsec <= s_tdata[213:184];
    end
  end

  // frame checks, ignored frames (lldp or a matching oui) first
  assign a_ignored = (a_etype == LLDP_TYPE) || (oui_enable && (a_oui == oui_value));
  assign a_bad = a_crc || (a_etype != tag_ethertype) || (a_flen < MIN_FRAME_BYTES) ||
                 (a_sub != subtype_value) ||
                 ((a_ver != version_tai) && (a_ver != version_utc)) ||
                 (a_tnsec >= {2'b00, NS_PER_S});

  always_comb begin
    if (a_ignored) begin
      a_cls = CLASS_IGNORED;
    end else if (a_bad) begin
      a_cls = CLASS_BAD;
    end else begin
      a_cls = CLASS_GOOD;
    end
  end

  // position within the 4 s ingress period, window threshold saturates at zero
  assign a_lower     = 33'(a_tsec[1:0]) * 33'(NS_PER_S) + 33'(a_tnsec);
  assign a_threshold = ({1'b0, window_ns} >= ROLLOVER_NS) ? 33'd0
                                                           : ROLLOVER_NS - {1'b0, window_ns};

  // stage b: tag and nic time in nanoseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_cls    <= a_cls;
      b_inside <= (a_lower >= a_threshold);
      b_tag_ns <= 62'(a_tsec) * 62'(NS_PER_S) + 62'(a_tnsec);
      b_nic_ns <= 62'(a_nsec) * 62'(NS_PER_S) + 62'(a_nnsec);
      b_tsec   <= a_tsec;
      b_tnsec  <= a_tnsec[29:0];
      b_nsec   <= a_nsec;
      b_nnsec  <= a_nnsec;
    end
  end

  // stage c: differences against the nic time
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_item.cls       <= b_cls;
      c_item.in_window <= b_inside;
      c_item.diff      <= 64'(b_tag_ns) - 64'(b_nic_ns);
      c_item.diff_roll <= 64'(b_tag_ns) - (64'(b_nic_ns) + 64'(ROLLOVER_NS));
      c_item.diff_neg  <= 64'(b_nic_ns) - 64'(b_tag_ns);
      c_item.tag_sec   <= b_tsec;
      c_item.tag_nsec  <= b_tnsec;
      c_item.nic_sec   <= b_nsec;
      c_item.nic_nsec  <= b_nnsec;
    end
  end

  // rollover decision and delta state
  swts_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .strip_enable (strip_enable),
    .item         (c_item),
    .take         (c_valid && r_ready),
    .result       (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_ready) begin
      r_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && c_valid) begin
      r_res <= dec_res;
    end
  end

  assign m_tvalid = r_valid;
  assign m_tuser  = r_res.cls;
  assign m_tdata  = {r_res.fixed, r_res.strip, r_res.nsec, r_res.sec};

endmodule
